/* hdl/svg_pkg.sv */
package svg_pkg;

  localparam int CNT_W = 11;
  localparam int RAD_W = 16;
  localparam int TEX_W = 17;
  localparam int NRM_W = 16;
  localparam int POS_W = 23;
  localparam int XW    = 34;
  localparam int ZW    = 34;
  localparam int IN_W  = 24;
  localparam int OUT_W = 152;

  // Configuration register indexes.
  localparam logic [1:0] REG_SECTOR_COUNT  = 2'd0;
  localparam logic [1:0] REG_STACK_COUNT   = 2'd1;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

  // CORDIC start value: the inverse gain in Q1.30.
  localparam logic signed [XW-1:0] X_INIT = XW'(652032874);

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [TEX_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } cordic_t;

  // Phase is in units of 2^-17 turn; the top two bits pick the quadrant.
  function automatic cordic_t cordic_seed(input logic [TEX_W-1:0] p);
    cordic_t c;
    c.x    = X_INIT;
    c.y    = '0;
    c.z    = ZW'({p[14:0], 15'd0});
    c.quad = p[16:15];
    return c;
  endfunction

endpackage

/* hdl/svg_div_cell.sv */
module svg_div_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [svg_pkg::CNT_W-1:0]   div_i,
  input  svg_pkg::div_t               d_i,
  output svg_pkg::div_t               d_o
);
  import svg_pkg::*;

  logic [CNT_W:0] sh;
  logic [CNT_W:0] diff;
  logic           ge;
  div_t           d_d, d_q;

  always_comb begin
    sh        = {d_i.rem, 1'b0};
    diff      = sh - {1'b0, div_i};
    ge        = (sh >= {1'b0, div_i});
    d_d.rem   = ge ? diff[CNT_W-1:0] : sh[CNT_W-1:0];
    d_d.quo   = {d_i.quo[TEX_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

/* hdl/svg_cordic_cell.sv */
module svg_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  svg_pkg::cordic_t  c_i,
  output svg_pkg::cordic_t  c_o
);
  import svg_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] at;
  cordic_t              c_d, c_q;

  always_comb begin
    dx     = c_i.y >>> IDX;
    dy     = c_i.x >>> IDX;
    at     = ZW'(ATAN_TURNS[IDX]);
    c_d    = c_i;
    if (!c_i.z[ZW-1]) begin
      c_d.x = c_i.x - dx;
      c_d.y = c_i.y + dy;
      c_d.z = c_i.z - at;
    end else begin
      c_d.x = c_i.x + dx;
      c_d.y = c_i.y - dy;
      c_d.z = c_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

/* hdl/sphere_vertex_generator_core.sv */
// Throughput: one vertex per cycle while the skid entry is empty; a chain of divider cells
// (one quotient bit each) feeds two chains of CORDIC cells (one rotation each), followed by
// four product and rounding stages.
// A two-entry output buffer lets input beats flow while one finished beat waits downstream.
// Reset (rst_ni low, asynchronous) clears all valid flags and loads sector_count 36,
// stack_count 18 and sphere_radius 256; pipeline data registers are not reset.
module sphere_vertex_generator_core #(
  parameter int MAX_SECTORS  = 1024,
  parameter int MAX_STACKS   = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // stack_index [10:0], sector_index [21:11], zero [23:22]
  input  logic [svg_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // position_x [22:0], position_y [45:23], position_z [68:46], normal_x [84:69],
  // normal_y [100:85], normal_z [116:101], tex_u [133:117], tex_v [150:134], zero [151]
  output logic [svg_pkg::OUT_W-1:0]  m_axis_tdata
);
  import svg_pkg::*;

  localparam int S   = CORDIC_STEPS;
  localparam int NST = 21 + S;
  localparam int TL  = S + 4;

  function automatic logic [CNT_W-1:0] eff_cnt(input logic [CNT_W-1:0] c, input int mx);
    if (c == '0) return CNT_W'(1);
    if (32'(c) > mx) return CNT_W'(mx);
    return c;
  endfunction

  function automatic logic signed [NRM_W-1:0] rnd16(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    t = $signed({v[XW-1], v}) + $signed((XW+1)'(32768));
    t = t >>> 16;
    if (t > $signed((XW+1)'(16384))) return NRM_W'(16384);
    if (t < -$signed((XW+1)'(16384))) return -NRM_W'(16384);
    return NRM_W'(t);
  endfunction

  function automatic logic signed [NRM_W-1:0] rnd14(input logic signed [31:0] p);
    logic signed [32:0] t;
    t = $signed({p[31], p}) + $signed(33'(8192));
    t = t >>> 14;
    if (t > $signed(33'(16384))) return NRM_W'(16384);
    if (t < -$signed(33'(16384))) return -NRM_W'(16384);
    return NRM_W'(t);
  endfunction

  function automatic logic [POS_W-1:0] rnd8(input logic signed [32:0] p);
    logic signed [33:0] t;
    t = $signed({p[32], p}) + $signed(34'(128));
    t = t >>> 8;
    return t[POS_W-1:0];
  endfunction

  // Configuration.
  logic [CNT_W-1:0] sector_cnt_q, stack_cnt_q;
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] sectors, stacks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_cnt_q <= CNT_W'(36);
      stack_cnt_q  <= CNT_W'(18);
      radius_q     <= RAD_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SECTOR_COUNT:  sector_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        REG_STACK_COUNT:   stack_cnt_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_SPHERE_RADIUS: radius_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sectors = eff_cnt(sector_cnt_q, MAX_SECTORS);
  assign stacks  = eff_cnt(stack_cnt_q, MAX_STACKS);

  // Flow control.
  logic             en;
  logic [NST-1:0]   vld_q;
  logic             out_vld_q, skid_vld_q;
  logic [OUT_W-1:0] out_q, skid_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Input stage: saturate indices and take the first quotient bit.
  logic [CNT_W-1:0] st_in, se_in, st_sat, se_sat;
  div_t             dstk [17];
  div_t             dsec [17];
  div_t             dstk_d, dsec_d;

  always_comb begin
    st_in      = s_axis_tdata[10:0];
    se_in      = s_axis_tdata[21:11];
    st_sat     = (st_in > stacks) ? stacks : st_in;
    se_sat     = (se_in > sectors) ? sectors : se_in;
    // A saturated index never exceeds its count, so the top bit is an equality test.
    dstk_d.quo = TEX_W'(st_sat == stacks);
    dstk_d.rem = (st_sat == stacks) ? '0 : st_sat;
    dsec_d.quo = TEX_W'(se_sat == sectors);
    dsec_d.rem = (se_sat == sectors) ? '0 : se_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dstk[0] <= dstk_d;
      dsec[0] <= dsec_d;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_div
    svg_div_cell u_stk (.clk_i, .en_i(en), .div_i(stacks),  .d_i(dstk[k]), .d_o(dstk[k+1]));
    svg_div_cell u_sec (.clk_i, .en_i(en), .div_i(sectors), .d_i(dsec[k]), .d_o(dsec[k+1]));
  end

  // CORDIC chains: stack phase is v, sector phase is 2u modulo a full turn.
  cordic_t cstk [S+1];
  cordic_t csec [S+1];

  assign cstk[0] = cordic_seed(dstk[16].quo);
  assign csec[0] = cordic_seed({dsec[16].quo[TEX_W-2:0], 1'b0});

  for (genvar k = 0; k < S; k++) begin : g_cordic
    svg_cordic_cell #(.IDX(k)) u_stk (.clk_i, .en_i(en), .c_i(cstk[k]), .c_o(cstk[k+1]));
    svg_cordic_cell #(.IDX(k)) u_sec (.clk_i, .en_i(en), .c_i(csec[k]), .c_o(csec[k+1]));
  end

  logic [TEX_W-1:0] texu_q [TL];
  logic [TEX_W-1:0] texv_q [TL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      texu_q[0] <= dsec[16].quo;
      texv_q[0] <= dstk[16].quo;
      for (int j = 1; j < TL; j++) begin
        texu_q[j] <= texu_q[j-1];
        texv_q[j] <= texv_q[j-1];
      end
    end
  end

  // Quadrant mapping and rounding to Q1.14.
  logic signed [XW-1:0]    ca, sa, cb, sb;
  logic signed [NRM_W-1:0] cos_a_q, sin_a_q, cos_b_q, sin_b_q;

  always_comb begin
    case (cstk[S].quad)
      2'd0:    begin ca =  cstk[S].x; sa =  cstk[S].y; end
      2'd1:    begin ca = -cstk[S].y; sa =  cstk[S].x; end
      2'd2:    begin ca = -cstk[S].x; sa = -cstk[S].y; end
      default: begin ca =  cstk[S].y; sa = -cstk[S].x; end
    endcase
    case (csec[S].quad)
      2'd0:    begin cb =  csec[S].x; sb =  csec[S].y; end
      2'd1:    begin cb = -csec[S].y; sb =  csec[S].x; end
      2'd2:    begin cb = -csec[S].x; sb = -csec[S].y; end
      default: begin cb =  csec[S].y; sb = -csec[S].x; end
    endcase
  end

  logic signed [31:0]      pnx_q, pnz_q;
  logic signed [NRM_W-1:0] ny1_q, nx_q, ny_q, nz_q, n3x_q, n3y_q, n3z_q;
  logic signed [32:0]      ppx_q, ppy_q, ppz_q;
  logic signed [RAD_W:0]   rad_s;

  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_a_q <= rnd16(ca);
      sin_a_q <= rnd16(sa);
      cos_b_q <= rnd16(cb);
      sin_b_q <= rnd16(sb);
      pnx_q   <= sin_a_q * cos_b_q;
      pnz_q   <= sin_a_q * sin_b_q;
      ny1_q   <= cos_a_q;
      nx_q    <= rnd14(pnx_q);
      nz_q    <= rnd14(pnz_q);
      ny_q    <= ny1_q;
      ppx_q   <= nx_q * rad_s;
      ppy_q   <= ny_q * rad_s;
      ppz_q   <= nz_q * rad_s;
      n3x_q   <= nx_q;
      n3y_q   <= ny_q;
      n3z_q   <= nz_q;
    end
  end

  logic [OUT_W-1:0] res;
  assign res = {1'b0, texv_q[TL-1], texu_q[TL-1], n3z_q, n3y_q, n3x_q,
                rnd8(ppz_q), rnd8(ppy_q), rnd8(ppx_q)};

  // Output register plus skid entry.
  logic             out_take, incoming;
  logic             out_vld_d, skid_vld_d;
  logic [OUT_W-1:0] out_d, skid_d;

  always_comb begin
    out_take   = out_vld_q && m_axis_tready;
    incoming   = en && vld_q[NST-1];
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (incoming) begin
      if (!out_vld_q || out_take) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid entry holds a beat while output is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !m_axis_tready |=> skid_vld_q && $stable(skid_q))
    else $error("skid entry lost while output stalled");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q[133:117] <= 17'd65536) && (out_q[150:134] <= 17'd65536))
    else $error("texture fraction above one");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ($signed(out_q[100:85]) <= 16'sd16384) &&
                  ($signed(out_q[100:85]) >= -16'sd16384))
    else $error("normal_y outside unit range");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

class vertex_scoreboard;
  int unsigned sector_cfg = 36;
  int unsigned stack_cfg  = 18;
  int unsigned radius_cfg = 256;
  logic [151:0] expected_vertices[$];
  int mismatches;
  int checked;

  static function longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  static function void sin_cos(int unsigned phase, output longint c, output longint s);
    longint x, y, z, dx, dy, cv, sv;
    int unsigned p;
    int unsigned quad;
    p = phase & 32'h1FFFF;
    quad = (p >> 15) & 3;
    z = longint'(p & 32'h7FFF) << 15;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(svg_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(svg_pkg::ATAN_TURNS[i]);
      end
    end
    case (quad)
      0: begin cv = x;  sv = y;  end
      1: begin cv = -y; sv = x;  end
      2: begin cv = -x; sv = -y; end
      default: begin cv = y; sv = -x; end
    endcase
    c = clamp_unit((cv + 32768) >>> 16);
    s = clamp_unit((sv + 32768) >>> 16);
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == svg_pkg::REG_SECTOR_COUNT) sector_cfg = val & 16'h7FF;
    else if (idx == svg_pkg::REG_STACK_COUNT) stack_cfg = val & 16'h7FF;
    else if (idx == svg_pkg::REG_SPHERE_RADIUS) radius_cfg = val;
  endfunction

  function void note_input(logic [10:0] stack_idx, logic [10:0] sector_idx);
    int unsigned sectors, stacks, st, se, u, v;
    longint ca, sa, cb, sb, nx, ny, nz, px, py, pz, r;
    logic [151:0] vertex_word;
    sectors = (sector_cfg == 0) ? 1 : (sector_cfg > 1024 ? 1024 : sector_cfg);
    stacks  = (stack_cfg == 0) ? 1 : (stack_cfg > 1024 ? 1024 : stack_cfg);
    st = (stack_idx > stacks) ? stacks : stack_idx;
    se = (sector_idx > sectors) ? sectors : sector_idx;
    u = 32'((longint'(se) << 16) / sectors);
    v = 32'((longint'(st) << 16) / stacks);
    sin_cos(v, ca, sa);
    sin_cos(u << 1, cb, sb);
    r = radius_cfg;
    nx = clamp_unit((sa * cb + 8192) >>> 14);
    ny = ca;
    nz = clamp_unit((sa * sb + 8192) >>> 14);
    px = (nx * r + 128) >>> 8;
    py = (ny * r + 128) >>> 8;
    pz = (nz * r + 128) >>> 8;
    vertex_word = {1'b0, v[16:0], u[16:0], nz[15:0], ny[15:0], nx[15:0],
                   pz[22:0], py[22:0], px[22:0]};
    expected_vertices = {expected_vertices, vertex_word};
  endfunction

  function void check_output(logic [151:0] got);
    logic [151:0] want;
    checked++;
    if (expected_vertices.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected output beat %h", got);
      return;
    end
    want = expected_vertices.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp px %h py %h pz %h n %h %h %h u %h v %h / got %h",
                 want[22:0], want[45:23], want[68:46], want[84:69], want[100:85],
                 want[116:101], want[133:117], want[150:134], got);
    end
  endfunction
endclass

module testbench;
  import svg_pkg::*;

  // An index past the register list; writes to it are dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;   // stack_index [10:0], sector_index [21:11]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;       // px, py, pz, nx, ny, nz, tex_u, tex_v from bit 0 up

  vertex_scoreboard sb = new();
  bit calm;            // no idling in the final part
  bit hold_off;        // long downstream stall request
  int idle_cycles;
  int vertices_sent;

  always #6 clk_i = ~clk_i;

  sphere_vertex_generator_core u_dut (.*);

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_input(s_axis_tdata[10:0], s_axis_tdata[21:11]);
      vertices_sent++;
    end
    if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Downstream ready: random stall bursts, or a long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_vertex(logic [10:0] stack_idx, logic [10:0] sector_idx);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, sector_idx, stack_idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_vertices.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_vertices(int count, int unsigned stacks, int unsigned sectors);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_vertex(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      else
        send_vertex(11'($urandom_range(0, stacks)), 11'($urandom_range(0, sectors)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: poles, equator, seam, saturation and all-ones indices.
    send_vertex(0, 0);
    send_vertex(18, 36);
    send_vertex(9, 9);
    send_vertex(9, 18);
    send_vertex(9, 27);
    send_vertex(4, 36);
    send_vertex(11'h7FF, 11'h7FF);
    send_vertex(1024, 1024);
    send_vertex(11'h555, 11'h2AA);
    send_vertex(11'h2AA, 11'h555);
    send_vertex(19, 37);
    drain();

    // Zero counts act as one; the largest radius.
    write_cfg(REG_SECTOR_COUNT, 0);
    write_cfg(REG_STACK_COUNT, 0);
    write_cfg(REG_SPHERE_RADIUS, 16'hFFFF);
    send_vertex(0, 0);
    send_vertex(1, 1);
    send_vertex(3, 5);
    drain();

    // Counts above the limit saturate; radius zero; a write to an unused index is dropped.
    write_cfg(REG_SECTOR_COUNT, 16'hFFFF);
    write_cfg(REG_STACK_COUNT, 16'h07FF);
    write_cfg(REG_SPHERE_RADIUS, 0);
    write_cfg(REG_UNUSED, 16'h1234);
    send_vertex(512, 256);
    send_vertex(1024, 1024);
    send_vertex(2047, 2047);
    drain();

    write_cfg(REG_SPHERE_RADIUS, 16'h8000);
    random_vertices(150, 1024, 1024);
    drain();

    write_cfg(REG_SECTOR_COUNT, 3);
    write_cfg(REG_STACK_COUNT, 2);
    write_cfg(REG_SPHERE_RADIUS, 16'h0180);
    random_vertices(80, 2, 3);
    drain();

    // The sink holds off for a long stretch while beats keep coming.
    write_cfg(REG_SECTOR_COUNT, 1000);
    write_cfg(REG_STACK_COUNT, 777);
    write_cfg(REG_SPHERE_RADIUS, 16'($urandom_range(0, 65535)));
    hold_off = 1'b1;
    random_vertices(200, 777, 1000);
    drain();

    calm = 1'b1;
    write_cfg(REG_SECTOR_COUNT, 36);
    write_cfg(REG_STACK_COUNT, 18);
    write_cfg(REG_SPHERE_RADIUS, 256);
    random_vertices(200, 18, 36);
    drain();

    $display("Covered %0d vertices over several grid sizes and radii, with stalls on both sides.",
             vertices_sent);
    if (sb.mismatches == 0 && sb.expected_vertices.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
